### src/rpa_pkg.sv
package rpa_pkg;

  // Fixed field widths of the request and response words.
  localparam int OP_BITS       = 3;
  localparam int PAGE_BITS     = 16;
  localparam int STATUS_BITS   = 2;
  localparam int REF_OUT_BITS  = 8;
  localparam int FREE_OUT_BITS = 17;

  // Default sizing of the allocator.
  localparam int DEF_NUM_PAGES  = 65536;
  localparam int DEF_COUNT_BITS = 8;

  // Configuration port.
  localparam int APB_ADDR_BITS  = 3;
  localparam int APB_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 1;
  localparam int LIMIT_BITS     = 17;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FIRST_USABLE = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAGE_LIMIT   = 1'b1;

  localparam logic [PAGE_BITS-1:0]  FIRST_USABLE_RESET = 16'd0;
  localparam logic [LIMIT_BITS-1:0] PAGE_LIMIT_RESET   = 17'd57344;

  typedef enum logic [OP_BITS-1:0] {
    OP_RELEASE  = 3'd0,
    OP_ALLOCATE = 3'd1,
    OP_QUERY    = 3'd2,
    OP_ADD_REF  = 3'd3,
    OP_DROP_REF = 3'd4
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_BAD_PAGE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

### src/rpa_channels.sv
// Request channel: one word per allocator operation.
interface rpa_req_if;
  import rpa_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_BITS-1:0]   operation;
  logic [PAGE_BITS-1:0] page_index;

  modport source (output valid, output operation, output page_index, input ready);
  modport sink   (input valid, input operation, input page_index, output ready);
endinterface

// Response channel: one word per accepted request.
interface rpa_rsp_if;
  import rpa_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [STATUS_BITS-1:0]   status;
  logic [PAGE_BITS-1:0]     result_page;
  logic [REF_OUT_BITS-1:0]  ref_count;
  logic [FREE_OUT_BITS-1:0] free_pages;

  modport source (output valid, output status, output result_page, output ref_count,
                  output free_pages, input ready);
  modport sink   (input valid, input status, input result_page, input ref_count,
                  input free_pages, output ready);
endinterface

### src/refcounted_page_allocator_top.sv
// Page frame allocator with per-page reference counts. On acceptance in the idle state
// a request reads the count memory and the top of the free-page stack into registers;
// in the execute state, once the response side has room, it writes back the new count,
// pushes or pops the stack and loads the response register. The two dependent accesses
// of an allocate (stack top, then that page's count) set this split. After reset the
// count memory is cleared one entry per cycle, NUM_PAGES entries in all, during which
// no request is accepted; configuration writes are taken at any time.
module refcounted_page_allocator_top #(
  parameter int NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
  parameter int COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  rpa_req_if.sink                           req,
  rpa_rsp_if.source                         rsp,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rpa_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [rpa_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [rpa_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                              pready
);
  import rpa_pkg::*;

  localparam int AW   = $clog2(NUM_PAGES);
  localparam int CW   = $clog2(NUM_PAGES + 1);
  localparam int WIDE = AW + PAGE_BITS;

  localparam logic [AW-1:0]         LAST_ADDR  = AW'(NUM_PAGES - 1);
  localparam logic [WIDE-1:0]       PAGES_WIDE = WIDE'(NUM_PAGES);
  localparam logic [CW-1:0]         STACK_FULL = CW'(NUM_PAGES);
  localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);

  // Configuration registers.
  logic [PAGE_BITS-1:0]      first_usable;
  logic [LIMIT_BITS-1:0]     page_limit;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic                      cfg_write;

  // Control.
  state_t         state;
  state_t         state_next;
  logic [AW-1:0]  clr_addr;
  logic [CW-1:0]  free_count;
  logic [CW-1:0]  free_count_next;
  logic           req_fire;
  logic           out_free;
  logic           exec_done;

  // Latched request.
  logic [OP_BITS-1:0]   op_q;
  logic [PAGE_BITS-1:0] page_q;

  // Memories and their registered read data.
  logic [COUNT_BITS-1:0] cnt_mem [NUM_PAGES];
  logic [PAGE_BITS-1:0]  stk_mem [NUM_PAGES];
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [PAGE_BITS-1:0]  stk_rdata;

  // Memory access signals.
  logic [WIDE-1:0]       req_page_wide;
  logic [AW-1:0]         cnt_raddr;
  logic [CW-1:0]         stk_top;
  logic [AW-1:0]         stk_raddr;
  logic                  cnt_we;
  logic [AW-1:0]         cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;
  logic                  stk_we;
  logic [AW-1:0]         stk_waddr;

  // Execute-stage computation.
  logic [WIDE-1:0]       page_wide;
  logic [WIDE-1:0]       pop_wide;
  logic                  page_ok;
  logic                  exec_cnt_we;
  logic [AW-1:0]         exec_cnt_addr;
  logic [COUNT_BITS-1:0] exec_cnt_val;
  logic [COUNT_BITS-1:0] new_count;
  logic [COUNT_BITS+REF_OUT_BITS-1:0] count_ext;
  logic [CW+FREE_OUT_BITS-1:0]        free_ext;
  logic [STATUS_BITS-1:0] res_status;
  logic [PAGE_BITS-1:0]   res_page;
  logic [REF_OUT_BITS-1:0] res_count;

  // APB register access; addresses decode on the word index bit.
  assign pready    = 1'b1;
  assign cfg_index = paddr[2];
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_usable <= FIRST_USABLE_RESET;
      page_limit   <= PAGE_LIMIT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_USABLE: first_usable <= pwdata[PAGE_BITS-1:0];
        REG_PAGE_LIMIT:   page_limit   <= pwdata[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_FIRST_USABLE: prdata = APB_DATA_BITS'(first_usable);
      REG_PAGE_LIMIT:   prdata = APB_DATA_BITS'(page_limit);
      default:          prdata = '0;
    endcase
  end

  // Handshake qualifiers.
  assign req_fire  = req.valid && req.ready;
  assign out_free  = !rsp.valid || rsp.ready;
  assign exec_done = (state == S_EXEC) && out_free;

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: if (clr_addr == LAST_ADDR) state_next = S_IDLE;
      S_IDLE:  if (req.valid) state_next = S_EXEC;
      S_EXEC:  if (out_free) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // State outputs.
  always_comb begin
    req.ready = 1'b0;
    case (state)
      S_IDLE:  req.ready = 1'b1;
      default: req.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_addr <= clr_addr + AW'(1);
    end
  end

  // Latch the request word on acceptance.
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_q   <= req.operation;
      page_q <= req.page_index;
    end
  end

  // Read addresses: the requested page's count and the current stack top.
  assign req_page_wide = {{AW{1'b0}}, req.page_index};
  assign cnt_raddr     = req_page_wide[AW-1:0];
  assign stk_top       = free_count - CW'(1);
  assign stk_raddr     = stk_top[AW-1:0];

  // Count memory: clearing pass or read-modify-write from the execute cycle.
  assign cnt_we    = (state == S_CLEAR) || (exec_done && exec_cnt_we);
  assign cnt_waddr = (state == S_CLEAR) ? clr_addr : exec_cnt_addr;
  assign cnt_wdata = (state == S_CLEAR) ? '0 : exec_cnt_val;

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    if (req_fire) cnt_rdata <= cnt_mem[cnt_raddr];
  end

  // Free-page stack memory.
  assign stk_waddr = free_count[AW-1:0];

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_waddr] <= page_q;
    if (req_fire) stk_rdata <= stk_mem[stk_raddr];
  end

  // Execute: work out the new count, stack change and response fields.
  assign page_wide = {{AW{1'b0}}, page_q};
  assign pop_wide  = {{AW{1'b0}}, stk_rdata};
  assign page_ok   = (page_q >= first_usable) && ({1'b0, page_q} < page_limit) &&
                     (page_wide < PAGES_WIDE);

  always_comb begin
    exec_cnt_we     = 1'b0;
    exec_cnt_addr   = page_wide[AW-1:0];
    exec_cnt_val    = cnt_rdata;
    new_count       = cnt_rdata;
    stk_we          = 1'b0;
    free_count_next = free_count;
    res_status      = ST_OK;
    res_page        = page_q;
    res_count       = '0;
    count_ext       = '0;

    if (op_t'(op_q) == OP_ALLOCATE) begin
      if (free_count == '0) begin
        res_status = ST_NO_FREE;
        res_page   = '0;
      end else begin
        free_count_next = free_count - CW'(1);
        res_page        = stk_rdata;
        res_count       = REF_OUT_BITS'(1);
        exec_cnt_addr   = pop_wide[AW-1:0];
        exec_cnt_val    = COUNT_ONE;
        exec_cnt_we     = pop_wide < PAGES_WIDE;
      end
    end else if (op_q <= OP_DROP_REF) begin
      if (!page_ok) begin
        res_status = ST_BAD_PAGE;
      end else begin
        case (op_t'(op_q))
          OP_RELEASE: begin
            if (cnt_rdata > COUNT_ONE) begin
              new_count = cnt_rdata - COUNT_ONE;
            end else begin
              new_count = '0;
              if (free_count < STACK_FULL) begin
                stk_we          = exec_done;
                free_count_next = free_count + CW'(1);
              end
            end
          end
          OP_ADD_REF:  if (cnt_rdata != '1) new_count = cnt_rdata + COUNT_ONE;
          OP_DROP_REF: if (cnt_rdata != '0) new_count = cnt_rdata - COUNT_ONE;
          default:     new_count = cnt_rdata;
        endcase
        exec_cnt_we  = 1'b1;
        exec_cnt_val = new_count;
        count_ext    = {{REF_OUT_BITS{1'b0}}, new_count};
        res_count    = count_ext[REF_OUT_BITS-1:0];
      end
    end
  end

  assign free_ext = {{FREE_OUT_BITS{1'b0}}, free_count_next};

  // Free count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_count <= '0;
    end else if (exec_done) begin
      free_count <= free_count_next;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (exec_done) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      rsp.status      <= res_status;
      rsp.result_page <= res_page;
      rsp.ref_count   <= res_count;
      rsp.free_pages  <= free_ext[FREE_OUT_BITS-1:0];
    end
  end

endmodule
